// File: rtl/core/gpd_pkg.sv
// ----------------------------------------------------------------------------
// Gradient predictor pixel decoder package
// Shared register map, configuration type and fixed widths.
// ----------------------------------------------------------------------------
package gpd_pkg;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_RED_MAX       = 3'd0,
    REG_GREEN_MAX     = 3'd1,
    REG_BLUE_MAX      = 3'd2,
    REG_RED_SHIFT     = 3'd3,
    REG_GREEN_SHIFT   = 3'd4,
    REG_BLUE_SHIFT    = 3'd5,
    REG_ROW_WIDTH     = 3'd6,
    REG_PACKED24_MODE = 3'd7
  } gpd_reg_e;

  // Fixed field widths.
  localparam int MaxW      = 10;
  localparam int ShiftW    = 5;
  localparam int RowWidthW = 12;
  localparam int PixelW    = 32;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  // Width used for row length compares; holds any row width up to 8192.
  localparam int WidthCmpW = 14;

  // Byte mask applied to every component in packed 24-bit mode.
  localparam logic [7:0] PackedMax = 8'hFF;

  // Reset values of the configuration registers.
  localparam logic [MaxW-1:0]      RstMax        = 10'd255;
  localparam logic [ShiftW-1:0]    RstRedShift   = 5'd16;
  localparam logic [ShiftW-1:0]    RstGreenShift = 5'd8;
  localparam logic [ShiftW-1:0]    RstBlueShift  = 5'd0;
  localparam logic [RowWidthW-1:0] RstRowWidth   = 12'd1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [MaxW-1:0]      red_max;
    logic [MaxW-1:0]      green_max;
    logic [MaxW-1:0]      blue_max;
    logic [ShiftW-1:0]    red_shift;
    logic [ShiftW-1:0]    green_shift;
    logic [ShiftW-1:0]    blue_shift;
    logic [RowWidthW-1:0] row_width;
    logic                 packed24_mode;
  } gpd_cfg_t;

endpackage

// File: rtl/core/gpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Gradient predictor configuration registers
// APB-style register file holding component masks, shifts, row width and mode.
// ----------------------------------------------------------------------------
module gpd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gpd_pkg::AddrW-1:0]  paddr,
  input  logic [gpd_pkg::DataW-1:0]  pwdata,
  output logic [gpd_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output gpd_pkg::gpd_cfg_t          cfg_o
);

  gpd_pkg::gpd_cfg_t cfg_q;
  gpd_pkg::gpd_reg_e reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = gpd_pkg::gpd_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_max       <= gpd_pkg::RstMax;
      cfg_q.green_max     <= gpd_pkg::RstMax;
      cfg_q.blue_max      <= gpd_pkg::RstMax;
      cfg_q.red_shift     <= gpd_pkg::RstRedShift;
      cfg_q.green_shift   <= gpd_pkg::RstGreenShift;
      cfg_q.blue_shift    <= gpd_pkg::RstBlueShift;
      cfg_q.row_width     <= gpd_pkg::RstRowWidth;
      cfg_q.packed24_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        gpd_pkg::REG_RED_MAX:       cfg_q.red_max       <= pwdata[gpd_pkg::MaxW-1:0];
        gpd_pkg::REG_GREEN_MAX:     cfg_q.green_max     <= pwdata[gpd_pkg::MaxW-1:0];
        gpd_pkg::REG_BLUE_MAX:      cfg_q.blue_max      <= pwdata[gpd_pkg::MaxW-1:0];
        gpd_pkg::REG_RED_SHIFT:     cfg_q.red_shift     <= pwdata[gpd_pkg::ShiftW-1:0];
        gpd_pkg::REG_GREEN_SHIFT:   cfg_q.green_shift   <= pwdata[gpd_pkg::ShiftW-1:0];
        gpd_pkg::REG_BLUE_SHIFT:    cfg_q.blue_shift    <= pwdata[gpd_pkg::ShiftW-1:0];
        gpd_pkg::REG_ROW_WIDTH:     cfg_q.row_width     <= pwdata[gpd_pkg::RowWidthW-1:0];
        gpd_pkg::REG_PACKED24_MODE: cfg_q.packed24_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      gpd_pkg::REG_RED_MAX:       prdata = gpd_pkg::DataW'(cfg_q.red_max);
      gpd_pkg::REG_GREEN_MAX:     prdata = gpd_pkg::DataW'(cfg_q.green_max);
      gpd_pkg::REG_BLUE_MAX:      prdata = gpd_pkg::DataW'(cfg_q.blue_max);
      gpd_pkg::REG_RED_SHIFT:     prdata = gpd_pkg::DataW'(cfg_q.red_shift);
      gpd_pkg::REG_GREEN_SHIFT:   prdata = gpd_pkg::DataW'(cfg_q.green_shift);
      gpd_pkg::REG_BLUE_SHIFT:    prdata = gpd_pkg::DataW'(cfg_q.blue_shift);
      gpd_pkg::REG_ROW_WIDTH:     prdata = gpd_pkg::DataW'(cfg_q.row_width);
      gpd_pkg::REG_PACKED24_MODE: prdata = gpd_pkg::DataW'(cfg_q.packed24_mode);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/gpd_row_store.sv
// ----------------------------------------------------------------------------
// Gradient predictor row store
// One-write, one-read memory of the previous row with registered,
// write-first read data.
// ----------------------------------------------------------------------------
module gpd_row_store #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  assign rdata_o = rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read of the address being written returns the new data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

endmodule

// File: rtl/core/gpd_comp_filter.sv
// ----------------------------------------------------------------------------
// Gradient predictor component filter
// Forms up + left - upper_left, clamps it to 0..max and adds the residual.
// ----------------------------------------------------------------------------
module gpd_comp_filter #(
  parameter int COMPONENT_BITS = 10
) (
  input  logic [COMPONENT_BITS-1:0] up_i,
  input  logic [COMPONENT_BITS-1:0] left_i,
  input  logic [COMPONENT_BITS-1:0] upper_left_i,
  input  logic                      col_zero_i,
  input  logic [COMPONENT_BITS-1:0] max_i,
  input  logic [COMPONENT_BITS-1:0] resid_i,
  output logic [COMPONENT_BITS-1:0] pix_o
);

  localparam int EstW = COMPONENT_BITS + 2;

  logic signed [EstW-1:0]   left_s;
  logic signed [EstW-1:0]   upper_left_s;
  logic signed [EstW-1:0]   est;
  logic [COMPONENT_BITS-1:0] est_clamped;

  // Left neighbors are missing in column zero.
  assign left_s       = col_zero_i ? '0 : signed'({2'b00, left_i});
  assign upper_left_s = col_zero_i ? '0 : signed'({2'b00, upper_left_i});
  assign est          = signed'({2'b00, up_i}) + left_s - upper_left_s;

  // Clamp the estimate into 0..max.
  always_comb begin
    if (est > signed'({2'b00, max_i})) begin
      est_clamped = max_i;
    end else if (est < 0) begin
      est_clamped = '0;
    end else begin
      est_clamped = est[COMPONENT_BITS-1:0];
    end
  end

  // Residual add, wrapped by the component mask.
  assign pix_o = (resid_i + est_clamped) & max_i;

endmodule

// File: rtl/core/gradient_predictor_pixel_decoder.sv
// ----------------------------------------------------------------------------
// Gradient predictor pixel decoder
// Undoes a gradient prediction filter on a raster pixel stream.
// ----------------------------------------------------------------------------
// Pipeline: an input pixel passes through the filter stage register and then
// the result register, and a stall at the output holds the filter stage.
// Throughput: one pixel per cycle while the output is not stalled; the row
// store read is issued at input acceptance and feeds the filter stage.
// Reset clears column, neighbors and pipeline valids, sets the first-row flag and
// loads the configuration registers with their reset values; the row store contents stay undefined until written.
// ----------------------------------------------------------------------------
module gradient_predictor_pixel_decoder #(
  parameter int MAX_ROW_WIDTH  = 2048,
  parameter int COMPONENT_BITS = 10,
  parameter int PIXEL_BITS     = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gpd_pkg::PixelW-1:0] in_pixel_i,
  input  logic                       start_rect_i,
  // Output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gpd_pkg::PixelW-1:0] out_pixel_o,
  output logic                       end_of_row_o,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gpd_pkg::AddrW-1:0]  paddr,
  input  logic [gpd_pkg::DataW-1:0]  pwdata,
  output logic [gpd_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  localparam int ColW   = $clog2(MAX_ROW_WIDTH);
  localparam int CmpW   = gpd_pkg::WidthCmpW;
  localparam int StoreW = 3 * COMPONENT_BITS;
  localparam logic [gpd_pkg::PixelW-1:0] PixMask =
    gpd_pkg::PixelW'((64'd1 << PIXEL_BITS) - 64'd1);

  typedef logic [2:0][COMPONENT_BITS-1:0] comp_vec_t;

  // Filter stage contents.
  typedef struct packed {
    logic [gpd_pkg::PixelW-1:0] pixel;
    logic [ColW-1:0]            col;
    logic                       first_row;
    logic                       last;
  } stage_t;

  gpd_pkg::gpd_cfg_t cfg;

  logic            in_accept;
  logic            s1_valid_q;
  stage_t          s1_q;
  logic            s1_advance;
  logic            s1_fire;

  logic [ColW-1:0] column_q;
  logic            first_row_q;
  logic [ColW-1:0] col_cur;
  logic            first_cur;
  logic [CmpW-1:0] width_cfg;
  logic [CmpW-1:0] width_eff;
  logic            last_cur;

  comp_vec_t       left_q;
  comp_vec_t       upper_left_q;
  comp_vec_t       store_rdata;
  comp_vec_t       up;
  comp_vec_t       maxv;
  comp_vec_t       resid;
  comp_vec_t       pix;
  logic [2:0][gpd_pkg::ShiftW-1:0] shiftv;
  logic [gpd_pkg::PixelW-1:0]      pixel_m;
  logic [gpd_pkg::PixelW-1:0]      word;

  logic                       out_valid_q;
  logic [gpd_pkg::PixelW-1:0] out_pixel_q;
  logic                       end_of_row_q;

  // Configuration registers.
  gpd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the filter stage moves when the result register is free or drains.
  assign s1_advance = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_advance;
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Effective row width: zero reads as one, and large values saturate.
  assign width_cfg = CmpW'(cfg.row_width);
  always_comb begin
    if (width_cfg == '0) begin
      width_eff = CmpW'(1);
    end else if (width_cfg > CmpW'(MAX_ROW_WIDTH)) begin
      width_eff = CmpW'(MAX_ROW_WIDTH);
    end else begin
      width_eff = width_cfg;
    end
  end

  // Column position of the incoming pixel.
  assign col_cur   = start_rect_i ? '0 : column_q;
  assign first_cur = start_rect_i || first_row_q;
  assign last_cur  = (CmpW'(col_cur) + CmpW'(1)) >= width_eff;

  // Raster position tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      first_row_q <= 1'b1;
    end else if (in_accept) begin
      if (last_cur) begin
        column_q    <= '0;
        first_row_q <= 1'b0;
      end else begin
        column_q    <= col_cur + ColW'(1);
        first_row_q <= first_cur;
      end
    end
  end

  // Input register of the filter stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.pixel     <= in_pixel_i;
      s1_q.col       <= col_cur;
      s1_q.first_row <= first_cur;
      s1_q.last      <= last_cur;
    end
  end

  // Previous row; read at acceptance, written when the pixel is decoded.
  gpd_row_store #(
    .DEPTH  (MAX_ROW_WIDTH),
    .DATA_W (StoreW)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_q.col),
    .wdata_i (pix),
    .re_i    (in_accept),
    .raddr_i (col_cur),
    .rdata_o (store_rdata)
  );

  // Component parameters and residuals; index 0 red, 1 green, 2 blue.
  assign shiftv[0] = cfg.red_shift;
  assign shiftv[1] = cfg.green_shift;
  assign shiftv[2] = cfg.blue_shift;
  assign pixel_m   = s1_q.pixel & PixMask;

  always_comb begin
    if (cfg.packed24_mode) begin
      maxv[0]  = COMPONENT_BITS'(gpd_pkg::PackedMax);
      maxv[1]  = COMPONENT_BITS'(gpd_pkg::PackedMax);
      maxv[2]  = COMPONENT_BITS'(gpd_pkg::PackedMax);
      resid[0] = COMPONENT_BITS'(pixel_m[7:0]);
      resid[1] = COMPONENT_BITS'(s1_q.pixel[15:8]);
      resid[2] = COMPONENT_BITS'(s1_q.pixel[23:16]);
    end else begin
      maxv[0]  = COMPONENT_BITS'(cfg.red_max);
      maxv[1]  = COMPONENT_BITS'(cfg.green_max);
      maxv[2]  = COMPONENT_BITS'(cfg.blue_max);
      resid[0] = COMPONENT_BITS'(pixel_m >> shiftv[0]);
      resid[1] = COMPONENT_BITS'(pixel_m >> shiftv[1]);
      resid[2] = COMPONENT_BITS'(pixel_m >> shiftv[2]);
    end
  end

  // The upper row is missing in the first row of a rectangle.
  assign up = s1_q.first_row ? '0 : store_rdata;

  // One filter per color component.
  for (genvar c = 0; c < 3; c++) begin : g_comp
    gpd_comp_filter #(
      .COMPONENT_BITS (COMPONENT_BITS)
    ) u_comp_filter (
      .up_i         (up[c]),
      .left_i       (left_q[c]),
      .upper_left_i (upper_left_q[c]),
      .col_zero_i   (s1_q.col == '0),
      .max_i        (maxv[c]),
      .resid_i      (resid[c]),
      .pix_o        (pix[c])
    );
  end

  // Pack the components at their shifts.
  assign word = ((gpd_pkg::PixelW'(pix[0]) << shiftv[0])
               | (gpd_pkg::PixelW'(pix[1]) << shiftv[1])
               | (gpd_pkg::PixelW'(pix[2]) << shiftv[2])) & PixMask;

  // Left and upper-left neighbors for the next pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      upper_left_q <= '0;
    end else if (s1_fire) begin
      left_q       <= pix;
      upper_left_q <= up;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_pixel_q  <= word;
      end_of_row_q <= s1_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign end_of_row_o = end_of_row_q;

  // A stall at the input only happens with a pixel held in the filter stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty filter stage");

  // A decoded pixel always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("decoded pixel did not reach the result register");

  // A rectangle start places the pixel at column zero of a first row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && start_rect_i) |=> (s1_q.col == '0 && s1_q.first_row))
    else $error("rectangle start not at column zero of a first row");

endmodule
